@@ hw/rtl/sha1_message_digest_defines.svh @@
// Assertion macros used by the SHA-1 digest top module.
// Depends on clk and rst being in scope where a macro is used.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

`ifndef SYNTHESIS
`define SHA1MD_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sha1md check failed");
`define SHA1MD_CHECK_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sha1md check failed");
`else
`define SHA1MD_CHECK(name, prop)
`define SHA1MD_CHECK_NEXT(name, pre, post)
`endif

`endif

@@ hw/rtl/sha1md_pkg.sv @@
// Shared constants, types and control structs of the SHA-1 digest block.
// No dependencies.
package sha1md_pkg;

  localparam int NumChain = 5;
  localparam int NumSched = 16;
  localparam int RndW     = 7;

  typedef logic [NumChain-1:0][31:0] chain_t;
  typedef logic [NumSched-1:0][31:0] sched_t;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;
  localparam chain_t ChainInit = {Iv4, Iv3, Iv2, Iv1, Iv0};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [RndW-1:0] Rnd20     = 7'd20;
  localparam logic [RndW-1:0] Rnd40     = 7'd40;
  localparam logic [RndW-1:0] Rnd60     = 7'd60;
  localparam logic [RndW-1:0] LastRound = 7'd79;

  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        clear;
    logic        len_ins;
    logic        shift;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } sched_cmd_t;

  typedef struct packed {
    logic            init;
    logic            load;
    logic            step;
    logic            fold;
    logic [RndW-1:0] rnd;
  } round_cmd_t;

endpackage

@@ hw/rtl/sha1_message_digest.sv @@
// SHA-1 digest over a byte stream. One byte per cycle is taken while idle; a
// full block runs load, 80 rounds and fold on the shared round unit. End of
// message: pad and one block, or pad, block, zero block with length and block
// when two final blocks are needed; then five digest words, one per output transfer.
// Synchronous active-high reset restores the initial chain and a zero count.
`include "sha1_message_digest_defines.svh"
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1md_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_FOLD  = 7'b0001000,
    S_PAD   = 7'b0010000,
    S_ZLEN  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  localparam logic [5:0] PosLast     = 6'd63;
  localparam logic [5:0] PosLenStart = 6'd56;
  localparam logic [2:0] EmitLast    = 3'd4;
  localparam logic [2:0] EmitDone    = 3'd5;

  state_t          state;
  logic [RndW-1:0] rnd;
  logic [63:0]     count;
  logic            fin_pend;
  logic            padded;
  logic            two_blk;
  logic [2:0]      emit_cnt;

  logic        in_acc;
  logic        out_free;
  logic        emit_done;
  logic [5:0]  pos;
  logic [31:0] w_cur;
  logic [31:0] chain_sel;
  chain_t      chain;
  sched_cmd_t  scmd;
  round_cmd_t  rcmd;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pos       = count[5:0];
  assign out_free  = !out_valid || !out_stall;
  assign emit_done = (state == S_EMIT) && out_free && (emit_cnt == EmitDone);

  always_comb begin
    scmd.wr_byte = in_acc && has_byte;
    scmd.pad     = (state == S_PAD);
    scmd.clear   = (state == S_ZLEN);
    scmd.len_ins = ((state == S_PAD) && (pos < PosLenStart)) || (state == S_ZLEN);
    scmd.shift   = (state == S_ROUND);
    scmd.pos     = pos;
    scmd.data    = data_byte;
    scmd.bit_len = {count[60:0], 3'b000};

    rcmd.init = emit_done;
    rcmd.load = (state == S_LOAD);
    rcmd.step = (state == S_ROUND);
    rcmd.fold = (state == S_FOLD);
    rcmd.rnd  = rnd;
  end

  sha1md_sched u_sched (
    .clk   (clk),
    .cmd   (scmd),
    .w_cur (w_cur)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rcmd),
    .w_in  (w_cur),
    .chain (chain)
  );

  always_comb begin
    case (emit_cnt)
      3'd0:    chain_sel = chain[0];
      3'd1:    chain_sel = chain[1];
      3'd2:    chain_sel = chain[2];
      3'd3:    chain_sel = chain[3];
      3'd4:    chain_sel = chain[4];
      default: chain_sel = chain[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      count     <= '0;
      fin_pend  <= 1'b0;
      padded    <= 1'b0;
      two_blk   <= 1'b0;
      emit_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (has_byte) begin
              count <= count + 64'd1;
            end
            if (end_of_message) begin
              fin_pend <= 1'b1;
            end
            if (has_byte && (pos == PosLast)) begin
              state <= S_LOAD;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == LastRound) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          emit_cnt <= '0;
          if (!fin_pend) begin
            state <= S_IDLE;
          end else if (!padded) begin
            state <= S_PAD;
          end else if (two_blk) begin
            state <= S_ZLEN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_PAD: begin
          padded  <= 1'b1;
          two_blk <= (pos >= PosLenStart);
          state   <= S_LOAD;
        end
        S_ZLEN: begin
          two_blk <= 1'b0;
          state   <= S_LOAD;
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_cnt == EmitDone) begin
              out_valid <= 1'b0;
              count     <= '0;
              fin_pend  <= 1'b0;
              padded    <= 1'b0;
              two_blk   <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              emit_cnt  <= emit_cnt + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free && (emit_cnt != EmitDone)) begin
      digest_word <= chain_sel;
      word_index  <= emit_cnt;
      last_word   <= (emit_cnt == EmitLast);
    end
  end

  `SHA1MD_CHECK(a_out_only_emit, out_valid |-> (state == S_EMIT))
  `SHA1MD_CHECK_NEXT(a_round_end, (state == S_ROUND) && (rnd == LastRound), state == S_FOLD)
  `SHA1MD_CHECK_NEXT(a_last_clears, out_valid && !out_stall && last_word, !out_valid)
  `SHA1MD_CHECK_NEXT(a_words_follow, out_valid && !out_stall && !last_word, out_valid)

endmodule

@@ hw/rtl/sha1md_sched.sv @@
// Block buffer and message schedule: 16-word shift line, byte loads, padding.
// Depends on sha1md_pkg.
module sha1md_sched (
  input  logic                   clk,
  input  sha1md_pkg::sched_cmd_t cmd,
  output logic [31:0]            w_cur
);
  import sha1md_pkg::*;

  sched_t      w;
  sched_t      blk;
  logic [31:0] x;
  logic [31:0] w_new;

  function automatic sched_t pad_words(input sched_t src, input logic [5:0] pos);
    sched_t res;
    res = src;
    for (int j = 0; j < NumSched; j++) begin
      for (int l = 0; l < 4; l++) begin
        if (4'(j) > pos[5:2]) begin
          res[j][8*(3-l) +: 8] = 8'h00;
        end else if (4'(j) == pos[5:2]) begin
          if (2'(l) == pos[1:0]) begin
            res[j][8*(3-l) +: 8] = PadByte;
          end else if (2'(l) > pos[1:0]) begin
            res[j][8*(3-l) +: 8] = 8'h00;
          end
        end
      end
    end
    return res;
  endfunction

  assign x     = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new = {x[30:0], x[31]};
  assign w_cur = w[0];

  always_comb begin
    blk = cmd.clear ? '0 : pad_words(w, cmd.pos);
    if (cmd.len_ins) begin
      blk[14] = cmd.bit_len[63:32];
      blk[15] = cmd.bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      w <= {w_new, w[NumSched-1:1]};
    end else if (cmd.wr_byte) begin
      w[cmd.pos[5:2]][{~cmd.pos[1:0], 3'b000} +: 8] <= cmd.data;
    end else if (cmd.pad || cmd.clear) begin
      w <= blk;
    end
  end

endmodule

@@ hw/rtl/sha1md_round.sv @@
// Shared SHA-1 round unit: working words a..e, one round per cycle while step is set, chain fold.
// Depends on sha1md_pkg.
module sha1md_round (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1md_pkg::round_cmd_t cmd,
  input  logic [31:0]            w_in,
  output sha1md_pkg::chain_t     chain
);
  import sha1md_pkg::*;

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;

  always_comb begin
    if (cmd.rnd < Rnd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (cmd.rnd < Rnd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (cmd.rnd < Rnd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= ChainInit;
    end else if (cmd.init) begin
      chain <= ChainInit;
    end else if (cmd.fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

endmodule
